/* src/tccw_pkg.sv */
// Shared types, constants and command codes for the text console cell writer.
// No dependencies; every other file in src imports this package.
package tccw_pkg;

   // field widths
   localparam int CMD_W  = 3;
   localparam int CHAR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;

   // default geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'b1110_0100;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_PUT_CHAR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_CHAR = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_CUR  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SCR_UP   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SCR_DN   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd6;

   // memory port operations
   typedef logic [2:0] mem_op_type;
   localparam mem_op_type MEM_NONE    = 3'd0;
   localparam mem_op_type MEM_EXEC    = 3'd1;  // run the captured command
   localparam mem_op_type MEM_ZERO    = 3'd2;  // write zero at sweep position
   localparam mem_op_type MEM_COPY_UP = 3'd3;  // read one row below sweep position
   localparam mem_op_type MEM_COPY_DN = 3'd4;  // read one row above sweep position

   // sweep pointer operations
   typedef logic [2:0] pos_op_type;
   localparam pos_op_type POS_HOLD     = 3'd0;
   localparam pos_op_type POS_ZERO     = 3'd1;
   localparam pos_op_type POS_INC      = 3'd2;
   localparam pos_op_type POS_DEC      = 3'd3;
   localparam pos_op_type POS_LAST     = 3'd4;
   localparam pos_op_type POS_BLANK_UP = 3'd5;  // first cell of the last row

   typedef struct packed {
      logic       capture;
      mem_op_type mem_op;
      pos_op_type pos_op;
      logic       rd_capture;
      logic       rsp_load;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             wrap_scroll;
      logic             read_hit;
      logic             pos_last;
      logic             pos_up_end;
      logic             pos_dn_end;
      logic             pos_row_end;
   } sts_type;

endpackage

/* src/tccw_ctrl.sv */
// Sequencer for the text console cell writer: handshakes, command sequencing
// and cell store sweeps. Depends on tccw_pkg.
module tccw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  tccw_pkg::sts_type sts,
   output tccw_pkg::ctl_type ctl
);
   import tccw_pkg::*;

   localparam logic [3:0] ST_INIT     = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_DECODE   = 4'd2;
   localparam logic [3:0] ST_RD_WAIT  = 4'd3;
   localparam logic [3:0] ST_CLR      = 4'd4;
   localparam logic [3:0] ST_UP_COPY  = 4'd5;
   localparam logic [3:0] ST_FLUSH_UP = 4'd6;
   localparam logic [3:0] ST_DN_COPY  = 4'd7;
   localparam logic [3:0] ST_FLUSH_DN = 4'd8;
   localparam logic [3:0] ST_BLANK_DN = 4'd9;
   localparam logic [3:0] ST_RESP     = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;
   logic       accept;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_free));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      ctl.mem_op = MEM_NONE;
      ctl.pos_op = POS_HOLD;
      ctl.capture = accept;
      case (state_ff)
         ST_INIT: begin
            ctl.mem_op = MEM_ZERO;
            ctl.pos_op = POS_INC;
            if (sts.pos_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            ctl.mem_op = MEM_EXEC;
            state_in   = ST_RESP;
            case (sts.cmd)
               CMD_PUT_CHAR: begin
                  if (sts.wrap_scroll) begin
                     ctl.pos_op = POS_ZERO;
                     state_in   = ST_UP_COPY;
                  end
               end
               CMD_CLEAR: begin
                  ctl.pos_op = POS_ZERO;
                  state_in   = ST_CLR;
               end
               CMD_SCR_UP: begin
                  ctl.pos_op = POS_ZERO;
                  state_in   = ST_UP_COPY;
               end
               CMD_SCR_DN: begin
                  ctl.pos_op = POS_LAST;
                  state_in   = ST_DN_COPY;
               end
               CMD_READ: begin
                  if (sts.read_hit) state_in = ST_RD_WAIT;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_RD_WAIT: begin
            ctl.rd_capture = 1'b1;
            state_in       = ST_RESP;
         end
         ST_CLR: begin
            ctl.mem_op = MEM_ZERO;
            ctl.pos_op = POS_INC;
            if (sts.pos_last) state_in = ST_RESP;
         end
         ST_UP_COPY: begin
            ctl.mem_op = MEM_COPY_UP;
            ctl.pos_op = POS_INC;
            if (sts.pos_up_end) state_in = ST_FLUSH_UP;
         end
         ST_FLUSH_UP: begin
            ctl.pos_op = POS_BLANK_UP;
            state_in   = ST_CLR;
         end
         ST_DN_COPY: begin
            ctl.mem_op = MEM_COPY_DN;
            ctl.pos_op = POS_DEC;
            if (sts.pos_dn_end) state_in = ST_FLUSH_DN;
         end
         ST_FLUSH_DN: begin
            ctl.pos_op = POS_ZERO;
            state_in   = ST_BLANK_DN;
         end
         ST_BLANK_DN: begin
            ctl.mem_op = MEM_ZERO;
            ctl.pos_op = POS_INC;
            if (sts.pos_row_end) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = accept ? ST_DECODE : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* src/tccw_datapath.sv */
// Datapath of the text console cell writer: cell store, cursor, attribute,
// sweep pointer and result registers. Depends on tccw_pkg.
module tccw_datapath #(
   parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tccw_pkg::ctl_type             ctl,
   output tccw_pkg::sts_type             sts,
   input  logic [tccw_pkg::CMD_W-1:0]    req_cmd,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tccw_pkg::COL_W-1:0]    req_col_arg,
   input  logic [tccw_pkg::ROW_W-1:0]    req_row_arg,
   input  logic                          csr_write_en,
   input  logic [tccw_pkg::ATTR_W-1:0]   csr_write_data,
   output logic [tccw_pkg::COL_W-1:0]    rsp_shown_col,
   output logic [tccw_pkg::ROW_W-1:0]    rsp_shown_row,
   output logic [tccw_pkg::CELL_W-1:0]   rsp_read_cell
);
   import tccw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int IDX_W  = $clog2(CELLS);
   localparam int COLX_W = COL_W + 1;
   localparam int ROWX_W = ROW_W + 1;

   localparam logic [IDX_W-1:0]  COLS_I     = IDX_W'(COLUMNS);
   localparam logic [IDX_W-1:0]  LAST_I     = IDX_W'(CELLS - 1);
   localparam logic [IDX_W-1:0]  BLANK_UP_I = IDX_W'(CELLS - COLUMNS);
   localparam logic [IDX_W-1:0]  UP_END_I   = IDX_W'(CELLS - COLUMNS - 1);
   localparam logic [IDX_W-1:0]  ROW_END_I  = IDX_W'(COLUMNS - 1);
   localparam logic [COLX_W-1:0] COLS_LIM   = COLX_W'(COLUMNS);
   localparam logic [ROWX_W-1:0] ROWS_LIM   = ROWX_W'(ROWS);
   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

   logic [CELL_W-1:0] mem [CELLS];

   logic [CMD_W-1:0]  cmd_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  wr_addr_ff;
   logic              wr_pend_ff, wr_pend_in;
   logic [CELL_W-1:0] rdata_ff;
   logic [CELL_W-1:0] read_cell_ff;
   logic [COL_W-1:0]  shown_col_ff;
   logic [ROW_W-1:0]  shown_row_ff;
   logic [CELL_W-1:0] shown_cell_ff;

   logic              in_range;
   logic              newline;
   logic [COLX_W-1:0] col_inc;
   logic              wrap;
   logic              on_last_row;
   logic [IDX_W-1:0]  req_idx;
   logic [IDX_W-1:0]  cur_idx;
   logic [CELL_W-1:0] new_cell;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;

   assign in_range    = ({1'b0, col_ff} < COLS_LIM) && ({1'b0, row_ff} < ROWS_LIM);
   assign newline     = (char_ff == NEWLINE_CODE);
   assign col_inc     = {1'b0, cur_col_ff} + COLX_W'(1);
   assign wrap        = newline || (col_inc == COLS_LIM);
   assign on_last_row = (cur_row_ff == ROW_LAST);
   assign req_idx     = IDX_W'(row_ff) * COLS_I + IDX_W'(col_ff);
   assign cur_idx     = IDX_W'(cur_row_ff) * COLS_I + IDX_W'(cur_col_ff);
   assign new_cell    = {attr_ff, char_ff};

   assign sts.cmd         = cmd_ff;
   assign sts.wrap_scroll = (cmd_ff == CMD_PUT_CHAR) && wrap && on_last_row;
   assign sts.read_hit    = (cmd_ff == CMD_READ) && in_range;
   assign sts.pos_last    = (pos_ff == LAST_I);
   assign sts.pos_up_end  = (pos_ff == UP_END_I);
   assign sts.pos_dn_end  = (pos_ff == COLS_I);
   assign sts.pos_row_end = (pos_ff == ROW_END_I);

   // cursor update for the captured command
   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (ctl.mem_op == MEM_EXEC) begin
         case (cmd_ff)
            CMD_PUT_CHAR: begin
               if (wrap) begin
                  cur_col_in = '0;
                  // last row: the scroll that follows keeps the cursor here
                  if (!on_last_row) cur_row_in = cur_row_ff + ROW_W'(1);
               end else begin
                  cur_col_in = col_inc[COL_W-1:0];
               end
            end
            CMD_SET_CUR: begin
               cur_col_in = ({1'b0, col_ff} < COLS_LIM) ? col_ff : COL_LAST;
               cur_row_in = ({1'b0, row_ff} < ROWS_LIM) ? row_ff : ROW_LAST;
            end
            CMD_CLEAR: begin
               cur_col_in = '0;
               cur_row_in = '0;
            end
            CMD_SCR_UP: begin
               if (cur_row_ff != '0) cur_row_in = cur_row_ff - ROW_W'(1);
            end
            CMD_SCR_DN: begin
               if (!on_last_row) cur_row_in = cur_row_ff + ROW_W'(1);
            end
            default: begin
               cur_col_in = cur_col_ff;
            end
         endcase
      end
   end

   // sweep pointer
   always_comb begin
      case (ctl.pos_op)
         POS_ZERO:     pos_in = '0;
         POS_INC:      pos_in = pos_ff + IDX_W'(1);
         POS_DEC:      pos_in = pos_ff - IDX_W'(1);
         POS_LAST:     pos_in = LAST_I;
         POS_BLANK_UP: pos_in = BLANK_UP_I;
         default:      pos_in = pos_ff;
      endcase
   end

   // store port selection; a pending copy write always wins
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = '0;
      mem_raddr = req_idx;
      if (wr_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wr_addr_ff;
         mem_wdata = rdata_ff;
      end else if (ctl.mem_op == MEM_ZERO) begin
         mem_we = 1'b1;
      end else if (ctl.mem_op == MEM_EXEC) begin
         if ((cmd_ff == CMD_PUT_CHAR) && !newline) begin
            mem_we    = 1'b1;
            mem_waddr = cur_idx;
            mem_wdata = new_cell;
         end else if ((cmd_ff == CMD_SET_CHAR) && in_range) begin
            mem_we    = 1'b1;
            mem_waddr = req_idx;
            mem_wdata = new_cell;
         end
      end
      case (ctl.mem_op)
         MEM_COPY_UP: mem_raddr = pos_ff + COLS_I;
         MEM_COPY_DN: mem_raddr = pos_ff - COLS_I;
         default:     mem_raddr = req_idx;
      endcase
   end

   assign wr_pend_in = (ctl.mem_op == MEM_COPY_UP) || (ctl.mem_op == MEM_COPY_DN);

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         attr_ff    <= ATTR_RESET;
         pos_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         pos_ff     <= pos_in;
         wr_pend_ff <= wr_pend_in;
         if (csr_write_en) attr_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= pos_ff;
      if (ctl.capture) begin
         cmd_ff  <= req_cmd;
         char_ff <= req_char_code;
         col_ff  <= req_col_arg;
         row_ff  <= req_row_arg;
      end
      if (ctl.mem_op == MEM_EXEC) begin
         read_cell_ff <= '0;
      end else if (ctl.rd_capture) begin
         read_cell_ff <= rdata_ff;
      end
      if (ctl.rsp_load) begin
         shown_col_ff  <= cur_col_ff;
         shown_row_ff  <= cur_row_ff;
         shown_cell_ff <= read_cell_ff;
      end
   end

   assign rsp_shown_col = shown_col_ff;
   assign rsp_shown_row = shown_row_ff;
   assign rsp_read_cell = shown_cell_ff;

endmodule

/* src/text_console_cell_writer.sv */
// Top level of the text console cell writer.
// Depends on tccw_pkg, tccw_ctrl and tccw_datapath.

// Text console of COLUMNS x ROWS 16-bit cells (attribute byte high, character
// low) held in a single-port-write, one-read block memory. Each accepted
// command returns exactly one response with the cursor after the command and,
// for a read, the cell (zero otherwise). After reset a clearing pass writes
// zero to every cell, one per cycle; req_stall stays high meanwhile, csr writes
// are taken throughout. The memory takes one write per cycle. Put char, set
// char, set cursor and the unused code pass through decode and response, back
// to back while the response side does not stall; a read inside the screen
// also waits for the registered memory read. Clear sweeps every cell.
// Scroll up, scroll down, and a put char that wraps on the last row make one
// copy per cycle, one flush, then blank one row.
// A new command is taken while the previous response still waits in the
// output register.
module text_console_cell_writer #(
   parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tccw_pkg::CMD_W-1:0]    req_cmd,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tccw_pkg::COL_W-1:0]    req_col_arg,
   input  logic [tccw_pkg::ROW_W-1:0]    req_row_arg,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tccw_pkg::COL_W-1:0]    rsp_shown_col,
   output logic [tccw_pkg::ROW_W-1:0]    rsp_shown_row,
   output logic [tccw_pkg::CELL_W-1:0]   rsp_read_cell,
   // attribute register
   input  logic                          csr_write_en,
   input  logic [tccw_pkg::ATTR_W-1:0]   csr_write_data
);
   import tccw_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // sequencer: handshakes, sweeps over the store
   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // store, cursor, attribute and the response payload
   tccw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_col_arg    (req_col_arg),
      .req_row_arg    (req_row_arg),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_shown_col  (rsp_shown_col),
      .rsp_shown_row  (rsp_shown_row),
      .rsp_read_cell  (rsp_read_cell)
   );

endmodule

/* test/console_check_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the text console cell writer: screen predictor plus response checks.
// Depends on tccw_pkg for field widths, command codes and the attribute reset value.
package console_check_pkg;
   import tccw_pkg::*;

   localparam int SCREEN_COLS  = DEF_COLUMNS;
   localparam int SCREEN_ROWS  = DEF_ROWS;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [CELL_W-1:0] read_value;
   } console_reply_type;

   class console_scoreboard;
      logic [CELL_W-1:0] cells [SCREEN_CELLS];
      int                cur_col;
      int                cur_row;
      logic [ATTR_W-1:0] attribute;
      console_reply_type replies_due [$];
      int                replies_seen   = 0;
      int                mismatch_count = 0;

      function void power_on();
         blank_screen();
         cur_col   = 0;
         cur_row   = 0;
         attribute = ATTR_RESET;
      endfunction

      function void set_attribute(input logic [ATTR_W-1:0] value);
         attribute = value;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      function void blank_screen();
         foreach (cells[i]) cells[i] = '0;
      endfunction

      function void shift_up();
         for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) cells[i] = cells[i + SCREEN_COLS];
         for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) cells[i] = '0;
         if (cur_row > 0) cur_row--;
      endfunction

      function void shift_down();
         for (int i = SCREEN_CELLS - 1; i >= SCREEN_COLS; i--) cells[i] = cells[i - SCREEN_COLS];
         for (int i = 0; i < SCREEN_COLS; i++) cells[i] = '0;
         if (cur_row < SCREEN_ROWS - 1) cur_row++;
      endfunction

      // newline writes nothing; a wrap on the last row scrolls and keeps the cursor there
      function void put_char(input logic [CHAR_W-1:0] code);
         if (code != NEWLINE_CODE) begin
            cells[cur_row * SCREEN_COLS + cur_col] = {attribute, code};
            cur_col++;
         end
         if (code == NEWLINE_CODE || cur_col >= SCREEN_COLS) begin
            cur_col = 0;
            if (cur_row >= SCREEN_ROWS - 1) shift_up();
            cur_row++;
         end
      endfunction

      // apply one accepted command to the screen and queue the response it must produce
      function void note_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] code,
                                 input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
         console_reply_type want;
         bit                hit;
         int                addr;
         hit             = (col < SCREEN_COLS) && (row < SCREEN_ROWS);
         addr            = int'(row) * SCREEN_COLS + int'(col);
         want.read_value = '0;
         case (cmd)
            CMD_PUT_CHAR: put_char(code);
            CMD_SET_CHAR: if (hit) cells[addr] = {attribute, code};
            CMD_SET_CUR: begin
               cur_col = (col < SCREEN_COLS) ? int'(col) : SCREEN_COLS - 1;
               cur_row = (row < SCREEN_ROWS) ? int'(row) : SCREEN_ROWS - 1;
            end
            CMD_CLEAR: begin
               blank_screen();
               cur_col = 0;
               cur_row = 0;
            end
            CMD_SCR_UP: shift_up();
            CMD_SCR_DN: shift_down();
            CMD_READ:   if (hit) want.read_value = cells[addr];
            default: ;
         endcase
         want.col = COL_W'(cur_col);
         want.row = ROW_W'(cur_row);
         replies_due.push_back(want);
      endfunction

      task report(input string line);
         $display("ERROR response %0d: %s", replies_seen, line);
         mismatch_count++;
      endtask

      task check_reply(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                       input logic [CELL_W-1:0] read_value);
         console_reply_type want;
         replies_seen++;
         if (replies_due.size() == 0) begin
            report("response with no command outstanding");
            return;
         end
         want = replies_due.pop_front();
         if (col !== want.col)
            report($sformatf("shown_col got %0d expected %0d", col, want.col));
         if (row !== want.row)
            report($sformatf("shown_row got %0d expected %0d", row, want.row));
         if (read_value !== want.read_value)
            report($sformatf("read_cell got %h expected %h", read_value, want.read_value));
      endtask
   endclass

endpackage

/* test/text_console_cell_writer_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for text_console_cell_writer: directed then random commands.
// Depends on tccw_pkg, console_check_pkg and the RTL under src.
module text_console_cell_writer_test;
   import tccw_pkg::*;
   import console_check_pkg::*;

   // code 7 has no meaning; the block must just report the cursor
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   // worst case is every command being a full-screen scroll plus stalls,
   // for ~1130 commands; this is several times that
   localparam int unsigned CYCLE_LIMIT = 10_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd        = '0;
   logic [CHAR_W-1:0]   req_char_code  = '0;
   logic [COL_W-1:0]    req_col_arg    = '0;
   logic [ROW_W-1:0]    req_row_arg    = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [COL_W-1:0]    rsp_shown_col;
   logic [ROW_W-1:0]    rsp_shown_row;
   logic [CELL_W-1:0]   rsp_read_cell;
   logic                csr_write_en   = 1'b0;
   logic [ATTR_W-1:0]   csr_write_data = '0;

   // chance in percent that the sender idles / the receiver stalls in a cycle
   int idle_pct  = 0;
   int stall_pct = 0;

   int unsigned cycle_count = 0;

   console_scoreboard screen;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_cell_writer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_col_arg    (req_col_arg),
      .req_row_arg    (req_row_arg),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_shown_col  (rsp_shown_col),
      .rsp_shown_row  (rsp_shown_row),
      .rsp_read_cell  (rsp_read_cell),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Response side: check the transfer seen at this edge (pre-edge values),
   // then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         screen.check_reply(rsp_shown_col, rsp_shown_row, rsp_read_cell);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("run stopped at cycle limit with %0d responses pending", screen.pending());
         $display("Mismatches found");
         $finish;
      end
   end

   // One command transfer. Idle cycles (valid low) go in front of it, so the
   // valid of back-to-back commands is never dropped and raised in one step.
   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] code,
                        input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_char_code <= code;
      req_col_arg   <= col;
      req_row_arg   <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      screen.note_command(cmd, code, col, row);
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (screen.pending() != 0) @(posedge clock);
   endtask

   // Only called with nothing in flight.
   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      screen.set_attribute(value);
   endtask

   // Random commands. Put char dominates so the cursor walks rows, wraps and
   // hits the last row; reads often land on the rows just written. Clear and
   // the scrolls are kept rare since each sweeps the whole screen.
   task automatic run_random(input int count);
      int               pick;
      logic [CMD_W-1:0] cmd;
      logic [CHAR_W-1:0] code;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(999);
         code = CHAR_W'($urandom_range(255));
         col  = COL_W'($urandom_range(SCREEN_COLS - 1));
         row  = ROW_W'($urandom_range(SCREEN_ROWS - 1));
         if (pick < 450) begin
            cmd = CMD_PUT_CHAR;
            if ($urandom_range(99) < 8) code = NEWLINE_CODE;
         end else if (pick < 600) begin
            cmd = CMD_SET_CHAR;
            if ($urandom_range(9) == 0) begin
               col = COL_W'($urandom_range(127));
               row = ROW_W'($urandom_range(31));
            end
         end else if (pick < 700) begin
            cmd  = CMD_SET_CUR;
            pick = $urandom_range(19);
            if (pick < 5) begin
               // close to the bottom right so put char wraps and scrolls soon
               col = COL_W'($urandom_range(SCREEN_COLS - 1, SCREEN_COLS - 10));
               row = ROW_W'($urandom_range(SCREEN_ROWS - 1, SCREEN_ROWS - 3));
            end else if (pick < 8) begin
               col = COL_W'($urandom_range(127));
               row = ROW_W'($urandom_range(31));
            end
         end else if (pick < 920) begin
            cmd = CMD_READ;
            if ($urandom_range(9) == 0) begin
               col = COL_W'($urandom_range(127));
               row = ROW_W'($urandom_range(31));
            end else if ($urandom_range(1) == 0) begin
               row = ROW_W'((screen.cur_row > 0) ? screen.cur_row - $urandom_range(1) : 0);
            end
         end else if (pick < 935) begin
            cmd = CMD_CLEAR;
         end else if (pick < 960) begin
            cmd = CMD_SCR_UP;
         end else if (pick < 985) begin
            cmd = CMD_SCR_DN;
         end else begin
            cmd = CMD_UNUSED;
            col = COL_W'($urandom_range(127));
            row = ROW_W'($urandom_range(31));
         end
         // now and then let the pipeline run dry
         if ($urandom_range(99) == 0) drain();
         issue(cmd, code, col, row);
      end
   endtask

   initial begin
      screen = new;
      screen.power_on();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset attribute ---
      issue(CMD_READ,     8'h00, 7'd0,   5'd0);    // cleared after reset
      issue(CMD_PUT_CHAR, 8'h41, 7'd0,   5'd0);
      issue(CMD_PUT_CHAR, 8'h00, 7'd0,   5'd0);
      issue(CMD_PUT_CHAR, 8'hFF, 7'd0,   5'd0);
      issue(CMD_READ,     8'h00, 7'd0,   5'd0);
      issue(CMD_PUT_CHAR, NEWLINE_CODE, 7'd0, 5'd0);
      issue(CMD_SET_CHAR, 8'h7E, 7'd79,  5'd24);
      issue(CMD_READ,     8'h00, 7'd79,  5'd24);
      issue(CMD_SET_CHAR, 8'h55, 7'd80,  5'd3);    // column out of range, dropped
      issue(CMD_SET_CHAR, 8'hAA, 7'd5,   5'd25);   // row out of range, dropped
      issue(CMD_READ,     8'h00, 7'd127, 5'd31);   // out of range reads zero
      issue(CMD_SET_CUR,  8'h00, 7'd127, 5'd31);   // saturates to the bottom right
      issue(CMD_PUT_CHAR, 8'h5A, 7'd0,   5'd0);    // wrap on last row scrolls up
      issue(CMD_READ,     8'h00, 7'd79,  5'd23);
      drain();

      // --- directed, attribute all ones ---
      write_attribute(8'hFF);
      issue(CMD_SET_CUR,  8'h00, 7'd78,  5'd10);
      issue(CMD_PUT_CHAR, 8'h31, 7'd0,   5'd0);
      issue(CMD_PUT_CHAR, 8'h32, 7'd0,   5'd0);    // last column, wraps to next row
      issue(CMD_SCR_DN,   8'h00, 7'd0,   5'd0);
      issue(CMD_READ,     8'h00, 7'd79,  5'd11);
      issue(CMD_SET_CUR,  8'h00, 7'd0,   5'd24);
      issue(CMD_SCR_DN,   8'h00, 7'd0,   5'd0);    // cursor already on last row
      issue(CMD_SET_CUR,  8'h00, 7'd3,   5'd0);
      issue(CMD_SCR_UP,   8'h00, 7'd0,   5'd0);    // cursor already on row 0
      issue(CMD_UNUSED,   8'hC3, 7'd100, 5'd17);
      issue(CMD_CLEAR,    8'h00, 7'd0,   5'd0);
      issue(CMD_READ,     8'h00, 7'd79,  5'd11);
      drain();

      // --- random: four idling modes, two attribute settings each ---
      for (int k = 0; k < 8; k++) begin
         case (k % 4)
            0:       write_attribute(8'h00);
            2:       write_attribute(8'hFF);
            default: write_attribute(ATTR_W'($urandom_range(255)));
         endcase
         case (k / 2)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 49; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 49; end
            default: begin idle_pct = 29; stall_pct = 29; end
         endcase
         run_random(138);
         drain();
      end

      // leave room for any stray response to show up
      stall_pct = 0;
      repeat (50) @(posedge clock);
      if (screen.mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
